FILE: rtl/gregorian_date_arithmetic_defines.svh
// ----------------------------------------------------------------------------
// gregorian date arithmetic assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define GDA_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// antecedent implies consequent on the following edge
`define GDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent on the same edge
`define GDA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define GDA_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define GDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define GDA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// types, codes and calendar helpers shared by the date arithmetic block
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int MAX_YEAR_DEF = 9999;
    localparam int RESET_YEAR   = 1996;

    localparam logic [13:0] MIN_YEAR_RST = 14'd1;

    // operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_MOVE    = 2'd1;
    localparam logic [1:0] OP_MEASURE = 2'd2;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_DATE  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    // floor(t / 100) = (t * 5243) >> 19 for every 14-bit t
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // elaboration-time day count of years 0 .. y-1
    function automatic int days_before_year_c(input int y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    localparam int RESET_SERIAL = days_before_year_c(RESET_YEAR);
    // bias that makes the reset date land on residue 0 (monday)
    localparam int WEEK_BIAS    = (7 - RESET_SERIAL % 7) % 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GIVEN,
        S_GIVEN2,
        S_FINISH,
        S_RANGE,
        S_SRCH_A,
        S_SRCH_B,
        S_YEAR_A,
        S_YEAR_B,
        S_MONTH,
        S_COMMIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         pad;
        logic signed [22:0] offset;
        logic [4:0]         in_day;
        logic [3:0]         in_month;
        logic [13:0]        in_year;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic [1:0]  error;
        logic [22:0] day_count;
        logic [2:0]  weekday;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
    } out_item_t;

    typedef struct packed {
        logic [22:0] dby;
        logic        leap;
    } year_info_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    // days of the year before the first of month m
    function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && m > 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // residue mod 7 by folding 3-bit groups, since 8 is 1 mod 7
    function automatic logic [2:0] mod7(input logic [22:0] u);
        logic [23:0] w;
        logic [5:0]  acc;
        logic [3:0]  f;
        logic [3:0]  g;
        w   = {1'b0, u};
        acc = 6'd0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + 6'(w[3*i +: 3]);
        end
        f = 4'(acc[5:3]) + 4'(acc[2:0]);
        g = 4'(f[3]) + 4'(f[2:0]);
        if (g >= 4'd7) begin
            g = g - 4'd7;
        end
        return g[2:0];
    endfunction

endpackage

FILE: rtl/gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// current gregorian date with load, move by days and measure to a date
// ----------------------------------------------------------------------------
//  channel   direction  handshake             content
//  s_        in         s_tvalid / s_tready   operation in tuser, given date and offset
//  m_        out        m_tvalid / m_tready   current date, weekday, day count, error
//  cfg_      in         cfg_valid / cfg_ready min_year, always ready
//
//  a load or measure runs the given, given2 and finish steps before the output register
//  loads, an unused code goes straight to it and a move out of range stops after the
//  range check; a move runs the 14-step year search (each step through the shared
//  year unit) and a month walk. s_tready is high only when the sequencer is idle;
//  a result waiting on m_tready holds the sequencer in its last step. reset restores
//  1996-01-01 and min_year 1.
// ----------------------------------------------------------------------------
`include "gregorian_date_arithmetic_defines.svh"

module gregorian_date_arithmetic #(
    parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // in_year, in_month, in_day, offset
    input  logic [1:0]  s_tuser,   // operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_year, out_month, out_day, weekday, day_count, error

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data   // min_year
);

    localparam logic [13:0] MAX_YEAR_W = 14'(MAX_YEAR);
    localparam int          DBY_END    = gda_pkg::days_before_year_c(MAX_YEAR + 1);
    localparam logic [23:0] DBY_END_W  = 24'(DBY_END);

    gda_pkg::state_t    state_reg, state_next;
    gda_pkg::in_item_t  s_item;
    gda_pkg::out_item_t m_tdata_reg, m_tdata_next;
    gda_pkg::year_info_t info;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [13:0] min_year_reg;

    logic [13:0] cur_year_reg, cur_year_next;
    logic [3:0]  cur_month_reg, cur_month_next;
    logic [4:0]  cur_day_reg, cur_day_next;
    logic [22:0] cur_serial_reg, cur_serial_next;

    logic [1:0]  op_reg, op_next;
    logic [13:0] gy_reg, gy_next;
    logic [3:0]  gm_reg, gm_next;
    logic [4:0]  gd_reg, gd_next;
    logic [24:0] s_reg, s_next;
    logic [13:0] y_reg, y_next;
    logic [3:0]  bit_reg, bit_next;
    logic [8:0]  rem_reg, rem_next;
    logic [3:0]  m_reg, m_next;
    logic        leap_reg, leap_next;
    logic        valid_reg, valid_next;
    logic [22:0] serial_g_reg, serial_g_next;
    logic [22:0] count_reg, count_next;
    logic [1:0]  err_reg, err_next;

    logic [13:0] cand;
    logic [13:0] y_arg;
    logic        in_fire;
    logic        out_load;
    logic        month_step;
    logic [4:0]  walk_len;
    logic [23:0] diff;

    logic        commit_step;
    logic        cur_date_ok;
    logic        bad_date_out;
    logic        zero_count;
    logic        err_known;

    assign s_item   = gda_pkg::in_item_t'(s_tdata);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = !m_tvalid_reg || m_tready;

    always_comb begin
        cand          = y_reg;
        cand[bit_reg] = 1'b1;
    end

    assign walk_len   = gda_pkg::month_len(m_reg, leap_reg);
    assign month_step = (m_reg < 4'd12) && (rem_reg >= 9'(walk_len));
    assign diff       = {1'b0, serial_g_reg} - {1'b0, cur_serial_reg};

    always_comb begin
        case (state_reg)
            gda_pkg::S_SRCH_A: y_arg = cand;
            gda_pkg::S_YEAR_A: y_arg = y_reg;
            default:           y_arg = gy_reg;
        endcase
    end

    gda_year_unit u_year (
        .aclk (aclk),
        .y_in (y_arg),
        .info (info)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gda_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == gda_pkg::OP_LOAD || s_tuser == gda_pkg::OP_MEASURE) begin
                        state_next = gda_pkg::S_GIVEN;
                    end else if (s_tuser == gda_pkg::OP_MOVE) begin
                        state_next = gda_pkg::S_RANGE;
                    end else begin
                        state_next = gda_pkg::S_OUT;
                    end
                end
            end
            gda_pkg::S_GIVEN:  state_next = gda_pkg::S_GIVEN2;
            gda_pkg::S_GIVEN2: state_next = gda_pkg::S_FINISH;
            gda_pkg::S_FINISH: state_next = gda_pkg::S_OUT;
            gda_pkg::S_RANGE: begin
                if (s_reg[24] || s_reg[23:0] >= DBY_END_W) begin
                    state_next = gda_pkg::S_OUT;
                end else begin
                    state_next = gda_pkg::S_SRCH_A;
                end
            end
            gda_pkg::S_SRCH_A: state_next = gda_pkg::S_SRCH_B;
            gda_pkg::S_SRCH_B: begin
                state_next = (bit_reg == 4'd0) ? gda_pkg::S_YEAR_A : gda_pkg::S_SRCH_A;
            end
            gda_pkg::S_YEAR_A: state_next = gda_pkg::S_YEAR_B;
            gda_pkg::S_YEAR_B: state_next = gda_pkg::S_MONTH;
            gda_pkg::S_MONTH: begin
                if (!month_step) begin
                    state_next = gda_pkg::S_COMMIT;
                end
            end
            gda_pkg::S_COMMIT: state_next = gda_pkg::S_OUT;
            gda_pkg::S_OUT: begin
                if (out_load) begin
                    state_next = gda_pkg::S_IDLE;
                end
            end
            default: state_next = gda_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready        = (state_reg == gda_pkg::S_IDLE);
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        cur_year_next   = cur_year_reg;
        cur_month_next  = cur_month_reg;
        cur_day_next    = cur_day_reg;
        cur_serial_next = cur_serial_reg;
        op_next         = op_reg;
        gy_next         = gy_reg;
        gm_next         = gm_reg;
        gd_next         = gd_reg;
        s_next          = s_reg;
        y_next          = y_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        m_next          = m_reg;
        leap_next       = leap_reg;
        valid_next      = valid_reg;
        serial_g_next   = serial_g_reg;
        count_next      = count_reg;
        err_next        = err_reg;

        case (state_reg)
            gda_pkg::S_IDLE: begin
                if (in_fire) begin
                    op_next    = s_tuser;
                    gy_next    = s_item.in_year;
                    gm_next    = s_item.in_month;
                    gd_next    = s_item.in_day;
                    s_next     = {2'b00, cur_serial_reg}
                                 + {{2{s_item.offset[22]}}, s_item.offset};
                    count_next = 23'd0;
                    err_next   = gda_pkg::ERR_OK;
                end
            end
            gda_pkg::S_GIVEN2: begin
                valid_next = (gy_reg >= min_year_reg) && (gy_reg <= MAX_YEAR_W)
                             && (gm_reg >= 4'd1) && (gm_reg <= 4'd12)
                             && (gd_reg >= 5'd1)
                             && (gd_reg <= gda_pkg::month_len(gm_reg, info.leap));
                serial_g_next = info.dby
                                + 23'(gda_pkg::days_before_month(gm_reg, info.leap))
                                + 23'(gd_reg) - 23'd1;
            end
            gda_pkg::S_FINISH: begin
                if (!valid_reg) begin
                    err_next = gda_pkg::ERR_DATE;
                end else if (op_reg == gda_pkg::OP_LOAD) begin
                    cur_year_next   = gy_reg;
                    cur_month_next  = gm_reg;
                    cur_day_next    = gd_reg;
                    cur_serial_next = serial_g_reg;
                end else if (diff[23] != diff[22]) begin
                    // count outside 23 bits saturates
                    err_next   = gda_pkg::ERR_RANGE;
                    count_next = diff[23] ? 23'h400000 : 23'h3FFFFF;
                end else begin
                    count_next = diff[22:0];
                end
            end
            gda_pkg::S_RANGE: begin
                if (s_reg[24] || s_reg[23:0] >= DBY_END_W) begin
                    err_next = gda_pkg::ERR_RANGE;
                end else begin
                    y_next   = 14'd0;
                    bit_next = 4'd13;
                end
            end
            gda_pkg::S_SRCH_B: begin
                // keep the bit when that year starts on or before the target day
                if ({1'b0, info.dby} <= s_reg[23:0]) begin
                    y_next = cand;
                end
                if (bit_reg != 4'd0) begin
                    bit_next = bit_reg - 4'd1;
                end
            end
            gda_pkg::S_YEAR_B: begin
                rem_next  = 9'(s_reg[22:0] - info.dby);
                leap_next = info.leap;
                m_next    = 4'd1;
            end
            gda_pkg::S_MONTH: begin
                if (month_step) begin
                    rem_next = rem_reg - 9'(walk_len);
                    m_next   = m_reg + 4'd1;
                end
            end
            gda_pkg::S_COMMIT: begin
                if (y_reg < min_year_reg) begin
                    err_next = gda_pkg::ERR_RANGE;
                end else begin
                    cur_year_next   = y_reg;
                    cur_month_next  = m_reg;
                    cur_day_next    = 5'(rem_reg + 9'd1);
                    cur_serial_next = s_reg[22:0];
                end
            end
            gda_pkg::S_OUT: begin
                if (out_load) begin
                    m_tvalid_next          = 1'b1;
                    m_tdata_next.pad       = 5'd0;
                    m_tdata_next.error     = err_reg;
                    m_tdata_next.day_count = count_reg;
                    m_tdata_next.weekday   = gda_pkg::mod7(cur_serial_reg
                                             + 23'(gda_pkg::WEEK_BIAS)) + 3'd1;
                    m_tdata_next.out_day   = cur_day_reg;
                    m_tdata_next.out_month = cur_month_reg;
                    m_tdata_next.out_year  = cur_year_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gda_pkg::S_IDLE;
            m_tvalid_reg   <= 1'b0;
            min_year_reg   <= gda_pkg::MIN_YEAR_RST;
            cur_year_reg   <= 14'(gda_pkg::RESET_YEAR);
            cur_month_reg  <= 4'd1;
            cur_day_reg    <= 5'd1;
            cur_serial_reg <= 23'(gda_pkg::RESET_SERIAL);
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            cur_year_reg   <= cur_year_next;
            cur_month_reg  <= cur_month_next;
            cur_day_reg    <= cur_day_next;
            cur_serial_reg <= cur_serial_next;
            if (cfg_valid) begin
                min_year_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg  <= m_tdata_next;
        op_reg       <= op_next;
        gy_reg       <= gy_next;
        gm_reg       <= gm_next;
        gd_reg       <= gd_next;
        s_reg        <= s_next;
        y_reg        <= y_next;
        bit_reg      <= bit_next;
        rem_reg      <= rem_next;
        m_reg        <= m_next;
        leap_reg     <= leap_next;
        valid_reg    <= valid_next;
        serial_g_reg <= serial_g_next;
        count_reg    <= count_next;
        err_reg      <= err_next;
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    assign commit_step  = (state_reg == gda_pkg::S_FINISH) || (state_reg == gda_pkg::S_COMMIT);
    assign cur_date_ok  = (cur_month_reg >= 4'd1) && (cur_month_reg <= 4'd12)
                          && (cur_day_reg != 5'd0) && (cur_year_reg <= MAX_YEAR_W);
    assign bad_date_out = m_tvalid_reg && (m_tdata_reg.error == gda_pkg::ERR_DATE);
    assign zero_count   = (m_tdata_reg.day_count == 23'd0);
    assign err_known    = !m_tvalid_reg || (m_tdata_reg.error inside
                          {gda_pkg::ERR_OK, gda_pkg::ERR_DATE, gda_pkg::ERR_RANGE});

    // the held date only ever changes in the two commit steps
    `GDA_ASSERT_NEXT(a_commit_only, aclk, aresetn, !commit_step, $stable(cur_serial_reg), "date moved")
    `GDA_ASSERT_ALWAYS(a_cur_date_sane, aclk, aresetn, cur_date_ok, "current date out of range")
    `GDA_ASSERT_SAME(a_date_err_cnt, aclk, aresetn, bad_date_out, zero_count, "count on bad date")
    `GDA_ASSERT_ALWAYS(a_err_code, aclk, aresetn, err_known, "unused error code")

endmodule

FILE: rtl/gda_year_unit.sv
// ----------------------------------------------------------------------------
// gda_year_unit
// shared year unit: days before a year and its leap flag, one register stage
// ----------------------------------------------------------------------------
module gda_year_unit (
    input  logic                 aclk,
    input  logic [13:0]          y_in,
    output gda_pkg::year_info_t  info
);

    logic [13:0] y_s1_reg;
    logic [13:0] t_s1_reg;
    logic [7:0]  q_s1_reg;
    logic        zero_s1_reg;

    logic [13:0] t_in;
    logic [26:0] prod;

    logic [13:0] r100;
    logic [22:0] y365;

    // t = y - 1, so that every rounded-up quotient becomes floor(t/k) + 1
    assign t_in = y_in - 14'd1;
    assign prod = 27'(t_in) * 27'(gda_pkg::RECIP_100);

    always_ff @(posedge aclk) begin
        y_s1_reg    <= y_in;
        t_s1_reg    <= t_in;
        q_s1_reg    <= prod[gda_pkg::RECIP_SHIFT +: 8];
        zero_s1_reg <= (y_in == 14'd0);
    end

    assign r100 = t_s1_reg - (14'(q_s1_reg) * 14'd100);
    assign y365 = 23'(y_s1_reg) * 23'd365;

    always_comb begin
        if (zero_s1_reg) begin
            info.dby  = 23'd0;
            info.leap = 1'b1;
        end else begin
            info.dby  = y365 + 23'(t_s1_reg[13:2]) + 23'(q_s1_reg[7:2]) + 23'd1
                        - 23'(q_s1_reg);
            // year % 100 == 0 exactly when t % 100 == 99; then % 400 needs q % 4 == 3
            info.leap = (y_s1_reg[1:0] == 2'd0)
                        && ((r100 != 14'd99) || (q_s1_reg[1:0] == 2'd3));
        end
    end

endmodule

FILE: tb/sv/gregorian_date_arithmetic_tb.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_tb
// self-checking bench for the date unit: a directed table covers field
// extremes, leap days, range limits and the unused code, then random load,
// move and measure streams run under several min_year bounds and idle mixes
// while a local calendar model predicts every result
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_YEAR    = gda_pkg::MAX_YEAR_DEF;
    localparam logic [1:0]  OP_NONE     = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 500;
    localparam int          PHASES      = 6;
    localparam int          PHASE_ITEMS = 230;
    localparam int          DIR_ROWS    = 31;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [1:0] op;
        int         yr;
        int         mo;
        int         dy;
        int         ofs;
        bit         fixed;   // expected result typed in below
        int         ey;
        int         em;
        int         ed;
        int         ewd;
        int         ecnt;
        logic [1:0] eerr;
    } dir_row_t;

    // a cfg row carries the new min_year in yr
    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_ITEM, OP_NONE, 0, 0, 0, 0, 1'b1, 1996, 1, 1, 1, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MEASURE, 1996, 1, 1, 0, 1'b1, 1996, 1, 1, 1, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MEASURE, 1996, 1, 8, 0, 1'b1, 1996, 1, 1, 1, 7, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MEASURE, 1995, 12, 31, 0, 1'b1, 1996, 1, 1, 1, -1,
          gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 1996, 13, 1, 0, 1'b1, 1996, 1, 1, 1, 0, gda_pkg::ERR_DATE},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 1996, 1, 0, 0, 1'b1, 1996, 1, 1, 1, 0, gda_pkg::ERR_DATE},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 1996, 2, 30, 0, 1'b1, 1996, 1, 1, 1, 0, gda_pkg::ERR_DATE},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 0, 1, 1, 0, 1'b1, 1996, 1, 1, 1, 0, gda_pkg::ERR_DATE},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 10000, 1, 1, 0, 1'b1, 1996, 1, 1, 1, 0, gda_pkg::ERR_DATE},
        '{ROW_ITEM, gda_pkg::OP_MEASURE, 16383, 15, 31, -1, 1'b1, 1996, 1, 1, 1, 0,
          gda_pkg::ERR_DATE},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, 4194303, 1'b1, 1996, 1, 1, 1, 0,
          gda_pkg::ERR_RANGE},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, -4194304, 1'b1, 1996, 1, 1, 1, 0,
          gda_pkg::ERR_RANGE},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 1996, 2, 29, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 1900, 2, 29, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 2000, 2, 29, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, 1, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 9999, 12, 31, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, 1, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 1, 1, 1, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, -1, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MEASURE, 9999, 12, 31, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_CFG, OP_NONE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, -1, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 0, 1, 1, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, -1, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_CFG, OP_NONE, 9999, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_LOAD, 9999, 6, 15, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MOVE, 0, 0, 0, -200, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_ITEM, gda_pkg::OP_MEASURE, 0, 1, 1, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK},
        '{ROW_CFG, OP_NONE, 1, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, gda_pkg::ERR_OK}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // in_year, in_month, in_day, offset
    logic [1:0]  s_tuser   = '0;   // operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // out_year, out_month, out_day, weekday, day_count, error
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [13:0] cfg_data  = '0;   // min_year

    // calendar model state
    int cal_year     = gda_pkg::RESET_YEAR;
    int cal_month    = 1;
    int cal_day      = 1;
    int cal_min_year = int'(gda_pkg::MIN_YEAR_RST);

    gda_pkg::out_item_t due_results [$];

    int          mismatches   = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    bit          stall_armed  = 1'b0;
    bit          stall_done   = 1'b0;
    int          stall_left   = 0;
    int unsigned cycle_cnt    = 0;
    int          op_seen [4]  = '{0, 0, 0, 0};
    int          err_seen [4] = '{0, 0, 0, 0};
    int          results_seen = 0;
    int          settings     = 0;

    gregorian_date_arithmetic #(
        .MAX_YEAR (MAX_YEAR)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_leap(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint month_days(longint m, longint y);
        longint len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = is_leap(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // days in years 0 .. y-1, year 0 itself is a leap year
    function automatic longint year_start(longint y);
        longint p;
        if (y <= 0) begin
            return 0;
        end
        p = y - 1;
        return 365 * y + 1 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic longint day_serial(longint y, longint m, longint d);
        longint s;
        s = year_start(y);
        for (longint k = 1; k < m; k++) begin
            s += month_days(k, y);
        end
        return s + d - 1;
    endfunction

    function automatic logic [2:0] weekday_of(longint s);
        longint r;
        r = (s - day_serial(gda_pkg::RESET_YEAR, 1, 1)) % 7;
        if (r < 0) begin
            r += 7;
        end
        return 3'(r + 1);
    endfunction

    function automatic bit date_ok(longint y, longint m, longint d);
        return y >= cal_min_year && y <= MAX_YEAR && m >= 1 && m <= 12 &&
               d >= 1 && d <= month_days(m, y);
    endfunction

    // applies one operation to the calendar state, returns the result it gives
    function automatic gda_pkg::out_item_t calendar_step(logic [1:0] op,
                                                         gda_pkg::in_item_t it);
        longint             cs;
        longint             s;
        longint             y;
        longint             m;
        longint             cnt;
        logic [1:0]         err;
        gda_pkg::out_item_t r;
        cs  = day_serial(cal_year, cal_month, cal_day);
        cnt = 0;
        err = gda_pkg::ERR_OK;
        case (op)
            gda_pkg::OP_LOAD: begin
                if (date_ok(it.in_year, it.in_month, it.in_day)) begin
                    cal_year  = it.in_year;
                    cal_month = it.in_month;
                    cal_day   = it.in_day;
                end else begin
                    err = gda_pkg::ERR_DATE;
                end
            end
            gda_pkg::OP_MOVE: begin
                s = cs + longint'(it.offset);
                if (s < 0 || s >= year_start(MAX_YEAR + 1)) begin
                    err = gda_pkg::ERR_RANGE;
                end else begin
                    // s / 366 never overshoots the year, so only walk up
                    y = s / 366;
                    while (year_start(y + 1) <= s) begin
                        y++;
                    end
                    s -= year_start(y);
                    m = 1;
                    while (m < 12 && s >= month_days(m, y)) begin
                        s -= month_days(m, y);
                        m++;
                    end
                    if (y < cal_min_year) begin
                        err = gda_pkg::ERR_RANGE;
                    end else begin
                        cal_year  = int'(y);
                        cal_month = int'(m);
                        cal_day   = int'(s + 1);
                    end
                end
            end
            gda_pkg::OP_MEASURE: begin
                if (date_ok(it.in_year, it.in_month, it.in_day)) begin
                    cnt = day_serial(it.in_year, it.in_month, it.in_day) - cs;
                    if (cnt > 4194303) begin
                        cnt = 4194303;
                        err = gda_pkg::ERR_RANGE;
                    end else if (cnt < -4194304) begin
                        cnt = -4194304;
                        err = gda_pkg::ERR_RANGE;
                    end
                end else begin
                    err = gda_pkg::ERR_DATE;
                end
            end
            default: ;
        endcase
        r           = '0;
        r.out_year  = 14'(cal_year);
        r.out_month = 4'(cal_month);
        r.out_day   = 5'(cal_day);
        r.weekday   = weekday_of(day_serial(cal_year, cal_month, cal_day));
        r.day_count = 23'(cnt);
        r.error     = err;
        return r;
    endfunction

    // mostly well-formed dates and offsets near the interesting boundaries
    function automatic void make_random_item(output logic [1:0] op,
                                             output gda_pkg::in_item_t it);
        int     r;
        int     y;
        int     m;
        longint tgt;
        longint ofs;
        it = '0;
        r  = $urandom_range(99);
        op = (r < 28) ? gda_pkg::OP_LOAD : (r < 62) ? gda_pkg::OP_MOVE :
             (r < 94) ? gda_pkg::OP_MEASURE : OP_NONE;
        if ($urandom_range(99) < 85) begin
            case ($urandom_range(7))
                0:       y = cal_min_year;
                1:       y = MAX_YEAR;
                default: y = $urandom_range(MAX_YEAR, cal_min_year);
            endcase
            m           = $urandom_range(12, 1);
            it.in_year  = 14'(y);
            it.in_month = 4'(m);
            it.in_day   = 5'($urandom_range(month_days(m, y), 1));
        end else begin
            it.in_year  = 14'($urandom);
            it.in_month = 4'($urandom);
            it.in_day   = 5'($urandom);
        end
        case ($urandom_range(9))
            0: ofs = longint'($signed(23'($urandom)));
            1: begin
                case ($urandom_range(3))
                    0:       tgt = year_start(cal_min_year);
                    1:       tgt = year_start(cal_min_year) - 1;
                    2:       tgt = year_start(MAX_YEAR + 1) - 1;
                    default: tgt = year_start(MAX_YEAR + 1);
                endcase
                ofs = tgt - day_serial(cal_year, cal_month, cal_day);
            end
            2, 3, 4, 5: ofs = longint'($urandom_range(800)) - 400;
            6, 7, 8:    ofs = longint'($urandom_range(120000)) - 60000;
            default:    ofs = longint'($urandom_range(3000000)) - 1500000;
        endcase
        it.offset = 23'(ofs);
    endfunction

    task automatic offer_item(input logic [1:0] op, input gda_pkg::in_item_t it,
                              input bit lit_on, input gda_pkg::out_item_t lit);
        gda_pkg::out_item_t want;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        want = calendar_step(op, it);
        due_results.push_back(lit_on ? lit : want);
        op_seen[op]++;
    endtask

    task automatic write_min_year(input int value);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_data  <= 14'(value);
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid    <= 1'b0;
        cal_min_year  = value;
        settings++;
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result side: check each transaction, then pick next ready
    always @(posedge aclk) begin
        gda_pkg::out_item_t got;
        gda_pkg::out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            err_seen[got.error]++;
            if (due_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("out_year", want.out_year, got.out_year);
                check_field("out_month", want.out_month, got.out_month);
                check_field("out_day", want.out_day, got.out_day);
                check_field("weekday", want.weekday, got.weekday);
                check_field("day_count", longint'($signed(want.day_count)),
                            longint'($signed(got.day_count)));
                check_field("error", want.error, got.error);
            end
        end
        if (stall_armed && !stall_done) begin
            stall_left = HOLD_CYCLES;
            stall_done = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time, due_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [1:0]         op;
        gda_pkg::in_item_t  it;
        gda_pkg::out_item_t lit;
        int                 phase_min [PHASES];
        phase_min = '{1, 0, $urandom_range(3000, 1), 9999, $urandom_range(9999), 1};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling on either side
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                write_min_year(dir_table[i].yr);
            end else begin
                it             = '0;
                it.in_year     = 14'(dir_table[i].yr);
                it.in_month    = 4'(dir_table[i].mo);
                it.in_day      = 5'(dir_table[i].dy);
                it.offset      = 23'(dir_table[i].ofs);
                lit            = '0;
                lit.out_year   = 14'(dir_table[i].ey);
                lit.out_month  = 4'(dir_table[i].em);
                lit.out_day    = 5'(dir_table[i].ed);
                lit.weekday    = 3'(dir_table[i].ewd);
                lit.day_count  = 23'(dir_table[i].ecnt);
                lit.error      = dir_table[i].eerr;
                offer_item(dir_table[i].op, it, dir_table[i].fixed, lit);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_min_year(phase_min[p]);
            case (p / 2)
                0: begin
                    snd_idle_pct = 30;
                    rcv_idle_pct = 66;
                end
                1: begin
                    snd_idle_pct = 66;
                    rcv_idle_pct = 30;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // long receiver hold while the sender keeps pushing
                if (p == 1 && i == 60) begin
                    stall_armed = 1'b1;
                end
                make_random_item(op, it);
                offer_item(op, it, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);

        $display("stimulus: %0d load, %0d move, %0d measure, %0d unused-code, %0d min_year writes",
                 op_seen[gda_pkg::OP_LOAD], op_seen[gda_pkg::OP_MOVE],
                 op_seen[gda_pkg::OP_MEASURE], op_seen[OP_NONE], settings);
        $display("results: %0d checked, %0d ok, %0d invalid date, %0d out of range, %0d mismatches",
                 results_seen, err_seen[gda_pkg::ERR_OK], err_seen[gda_pkg::ERR_DATE],
                 err_seen[gda_pkg::ERR_RANGE], mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/gda_pkg.sv
rtl/gda_year_unit.sv
rtl/gregorian_date_arithmetic.sv
tb/sv/gregorian_date_arithmetic_tb.sv
